/* rtl/sflow_sample_header_extractor_assert.svh */
// Assertion macros for the sFlow header extractor checker
`ifndef SFLOW_SAMPLE_HEADER_EXTRACTOR_ASSERT_SVH
`define SFLOW_SAMPLE_HEADER_EXTRACTOR_ASSERT_SVH

// implication checked on every rising clock edge outside reset
`define SHX_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication checked outside reset
`define SHX_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/shx_pkg.sv */
// ============================================================================
// shx_pkg
// Types and constants shared by the sFlow header extractor modules.
// ============================================================================
package shx_pkg;

    // parse phases of the datagram walker
    typedef enum logic [5:0] {
        PH_VER, PH_ADDR, PH_NSAMP, PH_DRAIN, PH_SKIP, PH_HDR,
        P4_TYPE, P4_RATE, P4_PDTYPE, P4_PROTO, P4_FLEN_E, P4_FLEN_O,
        P4_SNAP_E, P4_SNAP_O, P4_NEXT, P4_EXTTYPE, P4_RADDR, P4_PATHLEN,
        P4_ASNLEN, P4_ASN, P4_COMMLEN, P4_LPREF, P4_USER1, P4_USER2,
        P4_URL, P4_CVER, P5_FORMAT, P5_LEN_FLOW, P5_LEN_OTHER, P5_RATE,
        P5_NREC, P5_RTYPE, P5_RLEN_RAW, P5_RLEN_OTHER, P5_PROTO, P5_FLEN_E,
        P5_FLEN_O, P5_STRIP_E, P5_STRIP_O, P5_HLEN,
        GO_SAMPLE, GO_EXT, GO_SEG, GO_REC
    } t_phase;

    // result kinds
    localparam logic KIND_HDR = 1'b0;
    localparam logic KIND_ERR = 1'b1;

    // error codes
    localparam logic [1:0] ERR_VERSION = 2'd0;
    localparam logic [1:0] ERR_ADDR    = 2'd1;
    localparam logic [1:0] ERR_V4      = 2'd2;

    // v5 flow sample format and record length overhead
    localparam logic [11:0] FMT_MASK      = 12'hfff;
    localparam logic [31:0] RAW_FIXED_LEN = 32'd12;
    localparam logic [31:0] FCS_BYTES     = 32'd4;

    // v4 counter block skips in words
    localparam logic [31:0] CNT_GENERIC = 32'd22;
    localparam logic [31:0] CNT_ETH     = 32'd35;
    localparam logic [31:0] CNT_TR      = 32'd40;
    localparam logic [31:0] CNT_VG      = 32'd42;
    localparam logic [31:0] CNT_PROC    = 32'd7;

    // one classified word handed from front to back
    typedef struct packed {
        logic        kind;
        logic [31:0] word;
        logic [2:0]  valid_bytes;
        logic        first;
        logic        last;
        logic [31:0] rate;
        logic [31:0] frame_bytes;
        logic [1:0]  error_code;
    } t_item;

    // bytes to whole words, rounded up
    function automatic logic [31:0] words_for(input logic [31:0] n);
        words_for = {2'b00, n[31:2]} + {31'd0, |n[1:0]};
    endfunction

endpackage

/* rtl/shx_front.sv */
// ============================================================================
// shx_front
// Datagram walker: one accepted word per cycle, emits header words and errors.
// ============================================================================
module shx_front
    import shx_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic [31:0] i_word,
    input  logic        i_last,
    output logic        o_push,
    output t_item       o_item
);

    t_phase      r_phase, n_phase, r_after, n_after;
    logic [2:0]  r_ver, n_ver;
    logic [31:0] r_samp, n_samp, r_rec, n_rec, r_seg, n_seg, r_asn, n_asn;
    logic [31:0] r_skip, n_skip, r_hbytes, n_hbytes, r_rate, n_rate;
    logic [31:0] r_flen, n_flen;
    logic        r_first, n_first;

    // next state of the walker
    always_comb begin
        t_phase      dest;
        logic        go;
        logic [31:0] t;
        logic [31:0] vb;
        logic [33:0] room;
        n_phase = r_phase; n_after = r_after; n_ver = r_ver;
        n_samp = r_samp; n_rec = r_rec; n_seg = r_seg; n_asn = r_asn;
        n_skip = r_skip; n_hbytes = r_hbytes; n_rate = r_rate;
        n_flen = r_flen; n_first = r_first;
        o_push = 1'b0;
        o_item = '0;
        dest = PH_DRAIN; go = 1'b0; t = '0; vb = '0; room = '0;
        if (i_valid) begin
            case (r_phase)
                PH_VER: begin
                    if (i_word == 32'd4 || i_word == 32'd5) begin
                        n_ver = i_word[2:0]; n_phase = PH_ADDR;
                    end else begin
                        o_push = 1'b1; o_item.kind = KIND_ERR;
                        o_item.error_code = ERR_VERSION; n_phase = PH_DRAIN;
                    end
                end
                PH_ADDR: begin
                    if (i_word == 32'd1 || i_word == 32'd2) begin
                        t = ((i_word == 32'd1) ? 32'd3 : 32'd6)
                            + ((r_ver == 3'd5) ? 32'd1 : 32'd0);
                        n_skip = t; n_after = PH_NSAMP; n_phase = PH_SKIP;
                    end else begin
                        o_push = 1'b1; o_item.kind = KIND_ERR;
                        o_item.error_code = ERR_ADDR; n_phase = PH_DRAIN;
                    end
                end
                PH_NSAMP: begin
                    n_samp = i_word; dest = GO_SAMPLE; go = 1'b1;
                end
                PH_SKIP: begin
                    n_skip = r_skip - 32'd1;
                    if (n_skip == '0) begin
                        dest = r_after; go = 1'b1;
                    end
                end
                PH_HDR: begin
                    vb = (r_hbytes < 32'd4) ? r_hbytes : 32'd4;
                    n_hbytes = r_hbytes - vb;
                    o_push = 1'b1;
                    o_item.kind = KIND_HDR;
                    o_item.word = i_word;
                    o_item.valid_bytes = vb[2:0];
                    o_item.first = r_first;
                    o_item.last = (n_hbytes == '0);
                    o_item.rate = r_rate;
                    o_item.frame_bytes = r_flen - FCS_BYTES;
                    n_first = 1'b0;
                    if (r_ver == 3'd5 && r_skip != '0) n_skip = r_skip - 32'd1;
                    if (n_hbytes == '0) begin
                        if (r_ver == 3'd5) begin
                            t = n_skip; dest = GO_REC;
                        end else begin
                            n_phase = P4_NEXT;
                        end
                    end
                end
                P4_TYPE: begin
                    if (i_word == 32'd1) begin
                        t = 32'd2; dest = P4_RATE;
                    end else if (i_word == 32'd2) begin
                        t = 32'd3; dest = P4_CVER;
                    end else begin
                        o_push = 1'b1; o_item.kind = KIND_ERR;
                        o_item.error_code = ERR_V4; n_phase = PH_DRAIN;
                    end
                end
                P4_RATE: begin
                    n_rate = i_word; t = 32'd4; dest = P4_PDTYPE;
                end
                P4_PDTYPE: begin
                    if (i_word == 32'd1) n_phase = P4_PROTO;
                    else if (i_word == 32'd2) begin
                        t = 32'd8; dest = P4_NEXT;
                    end else if (i_word == 32'd3) begin
                        t = 32'd14; dest = P4_NEXT;
                    end else begin
                        o_push = 1'b1; o_item.kind = KIND_ERR;
                        o_item.error_code = ERR_V4; n_phase = PH_DRAIN;
                    end
                end
                P4_PROTO: n_phase = (i_word == 32'd1) ? P4_FLEN_E : P4_FLEN_O;
                P4_FLEN_E: begin
                    n_flen = i_word; n_phase = P4_SNAP_E;
                end
                P4_FLEN_O: begin
                    n_flen = i_word; n_phase = P4_SNAP_O;
                end
                P4_SNAP_E: begin
                    if (i_word == '0) n_phase = P4_NEXT;
                    else begin
                        n_hbytes = i_word; n_first = 1'b1; n_phase = PH_HDR;
                    end
                end
                P4_SNAP_O: begin
                    t = words_for(i_word); dest = P4_NEXT;
                end
                P4_NEXT: begin
                    n_rec = i_word; dest = GO_EXT; go = 1'b1;
                end
                P4_EXTTYPE: begin
                    case (i_word)
                        32'd1: begin t = 32'd4; dest = GO_EXT; end
                        32'd2: n_phase = P4_RADDR;
                        32'd3: begin t = 32'd3; dest = P4_PATHLEN; end
                        32'd4: n_phase = P4_USER1;
                        32'd5: begin t = 32'd1; dest = P4_URL; end
                        default: begin
                            o_push = 1'b1; o_item.kind = KIND_ERR;
                            o_item.error_code = ERR_V4; n_phase = PH_DRAIN;
                        end
                    endcase
                end
                P4_RADDR: begin
                    if (i_word == 32'd1) begin
                        t = 32'd3; dest = GO_EXT;
                    end else if (i_word == 32'd2) begin
                        t = 32'd6; dest = GO_EXT;
                    end else begin
                        o_push = 1'b1; o_item.kind = KIND_ERR;
                        o_item.error_code = ERR_V4; n_phase = PH_DRAIN;
                    end
                end
                P4_PATHLEN: begin
                    n_seg = i_word; dest = GO_SEG; go = 1'b1;
                end
                P4_ASNLEN: begin
                    n_asn = i_word;
                    if (i_word == '0) begin
                        dest = GO_SEG; go = 1'b1;
                    end else n_phase = P4_ASN;
                end
                P4_ASN: begin
                    n_asn = r_asn - 32'd1;
                    if (n_asn == '0) begin
                        dest = GO_SEG; go = 1'b1;
                    end
                end
                P4_COMMLEN: begin
                    t = i_word; dest = P4_LPREF;
                end
                P4_LPREF: begin
                    dest = GO_EXT; go = 1'b1;
                end
                P4_USER1: begin
                    t = words_for(i_word); dest = P4_USER2;
                end
                P4_USER2, P4_URL: begin
                    t = words_for(i_word); dest = GO_EXT;
                end
                P4_CVER: begin
                    case (i_word)
                        32'd1, 32'd4, 32'd6: begin t = CNT_GENERIC; dest = GO_SAMPLE; end
                        32'd2: begin t = CNT_ETH; dest = GO_SAMPLE; end
                        32'd3: begin t = CNT_TR; dest = GO_SAMPLE; end
                        32'd5: begin t = CNT_VG; dest = GO_SAMPLE; end
                        32'd7: begin t = CNT_PROC; dest = GO_SAMPLE; end
                        default: begin
                            o_push = 1'b1; o_item.kind = KIND_ERR;
                            o_item.error_code = ERR_V4; n_phase = PH_DRAIN;
                        end
                    endcase
                end
                P5_FORMAT: n_phase = ((i_word[11:0] & FMT_MASK) == 12'd1)
                                     ? P5_LEN_FLOW : P5_LEN_OTHER;
                P5_LEN_FLOW: begin
                    t = 32'd2; dest = P5_RATE;
                end
                P5_LEN_OTHER: begin
                    t = words_for(i_word); dest = GO_SAMPLE;
                end
                P5_RATE: begin
                    n_rate = i_word; t = 32'd4; dest = P5_NREC;
                end
                P5_NREC: begin
                    n_rec = i_word; dest = GO_REC; go = 1'b1;
                end
                P5_RTYPE: n_phase = (i_word == 32'd1) ? P5_RLEN_RAW : P5_RLEN_OTHER;
                P5_RLEN_RAW: begin
                    n_skip = i_word; n_phase = P5_PROTO;
                end
                P5_RLEN_OTHER: begin
                    t = words_for(i_word); dest = GO_REC;
                end
                P5_PROTO: n_phase = (i_word == 32'd1) ? P5_FLEN_E : P5_FLEN_O;
                P5_FLEN_E: begin
                    n_flen = i_word; n_phase = P5_STRIP_E;
                end
                P5_FLEN_O: begin
                    n_flen = i_word; n_phase = P5_STRIP_O;
                end
                P5_STRIP_E, P5_STRIP_O: begin
                    t = words_for(r_skip - RAW_FIXED_LEN);
                    if (r_phase == P5_STRIP_E && t != '0) begin
                        n_skip = t; n_phase = P5_HLEN; t = '0;
                    end else dest = GO_REC;
                end
                P5_HLEN: begin
                    n_skip = r_skip - 32'd1;
                    room = {n_skip, 2'b00};
                    if ({2'b00, i_word} < room) t = i_word;
                    else t = room[31:0];
                    if (t == '0) begin
                        t = n_skip; dest = GO_REC;
                    end else begin
                        n_hbytes = t; n_first = 1'b1; n_phase = PH_HDR; t = '0;
                    end
                end
                default: ;
            endcase

            // begin a skip or resolve the destination
            if (dest != PH_DRAIN && !go && t != '0) begin
                n_skip = t; n_after = dest; n_phase = PH_SKIP;
            end else if (dest != PH_DRAIN) begin
                go = 1'b1;
            end
            if (go) begin
                case (dest)
                    GO_SAMPLE: begin
                        if (n_samp == '0) n_phase = PH_DRAIN;
                        else begin
                            n_samp = n_samp - 32'd1;
                            n_phase = (r_ver == 3'd5) ? P5_FORMAT : P4_TYPE;
                        end
                    end
                    GO_EXT, GO_REC: begin
                        if (n_rec != '0) begin
                            n_rec = n_rec - 32'd1;
                            n_phase = (dest == GO_EXT) ? P4_EXTTYPE : P5_RTYPE;
                        end else if (n_samp == '0) n_phase = PH_DRAIN;
                        else begin
                            n_samp = n_samp - 32'd1;
                            n_phase = (r_ver == 3'd5) ? P5_FORMAT : P4_TYPE;
                        end
                    end
                    GO_SEG: begin
                        if (n_seg == '0) n_phase = P4_COMMLEN;
                        else begin
                            n_seg = n_seg - 32'd1; n_skip = 32'd1;
                            n_after = P4_ASNLEN; n_phase = PH_SKIP;
                        end
                    end
                    default: n_phase = dest;
                endcase
            end
            if (i_last) n_phase = PH_VER;
        end
    end

    // walker registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_VER; r_after <= PH_VER; r_ver <= '0;
            r_samp <= '0; r_rec <= '0; r_seg <= '0; r_asn <= '0;
            r_skip <= '0; r_hbytes <= '0; r_rate <= '0; r_flen <= '0;
            r_first <= 1'b0;
        end else begin
            r_phase <= n_phase; r_after <= n_after; r_ver <= n_ver;
            r_samp <= n_samp; r_rec <= n_rec; r_seg <= n_seg; r_asn <= n_asn;
            r_skip <= n_skip; r_hbytes <= n_hbytes; r_rate <= n_rate;
            r_flen <= n_flen; r_first <= n_first;
        end
    end

endmodule

/* rtl/shx_queue.sv */
// ============================================================================
// shx_queue
// Small FIFO between walker and output stage.
// ============================================================================
module shx_queue
    import shx_pkg::*;
#(
    parameter int DEPTH = 4
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_item,
    input  logic  i_pop,
    output logic  o_empty,
    output logic  o_afull,
    output t_item o_item
);
    localparam int AW = $clog2(DEPTH);

    t_item            r_mem [DEPTH];
    logic [AW-1:0]    r_wp, r_rp;
    logic [AW:0]      r_cnt;

    assign o_empty = (r_cnt == '0);
    // leaves room for words still in flight from the input side
    assign o_afull = (r_cnt >= (AW+1)'(DEPTH - 2));
    assign o_item  = r_mem[r_rp];

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_item;
    end

    // pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0; r_rp <= '0; r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= (r_wp == AW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
            if (i_pop)  r_rp <= (r_rp == AW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
            r_cnt <= r_cnt + (AW+1)'(i_push) - (AW+1)'(i_pop);
        end
    end
endmodule

/* rtl/shx_back.sv */
// ============================================================================
// shx_back
// Output stage: multiplies rate by frame bytes and holds the result word.
// ============================================================================
module shx_back
    import shx_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_empty,
    input  t_item        i_item,
    output logic         o_pop,
    input  logic         i_ready,
    output logic         o_valid,
    output t_item        o_item,
    output logic [31:0]  o_scaled
);
    logic        r_valid;
    t_item       r_item;
    logic [31:0] r_scaled;
    logic [31:0] prod;

    // only the low 32 bits of the product are kept
    assign prod   = i_item.frame_bytes * i_item.rate;
    assign o_pop  = !i_empty && (!r_valid || i_ready);
    assign o_valid = r_valid;
    assign o_item  = r_item;
    assign o_scaled = r_scaled;

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_valid <= 1'b0;
        else if (o_pop) r_valid <= 1'b1;
        else if (i_ready) r_valid <= 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_item   <= i_item;
            r_scaled <= prod;
        end
    end
endmodule

/* rtl/sflow_sample_header_extractor.sv */
// Throughput: one datagram word per cycle while the output side takes words.
// The walker state machine handles every word in the cycle it is accepted.
// A four-entry queue decouples walker and output; tready drops when it is nearly full.
// Reset (synchronous, active low) returns the walker to datagram start.
module sflow_sample_header_extractor
    import shx_pkg::*;
#(
    parameter int QDEPTH = 4
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    input  logic [31:0]   s_axis_tdata,   // word
    input  logic          s_axis_tlast,   // last_word
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    // header_word, valid_bytes, first_of_header, sample_rate, frame_bytes,
    // scaled_bytes, error_code, zero fill
    output logic [135:0]  m_axis_tdata,
    output logic          m_axis_tuser,   // kind
    output logic          m_axis_tlast    // last_of_header; first_of_header in tdata
);
    logic  push, pop, empty, afull, bvalid;
    t_item fitem, qitem, bitem;
    logic [31:0] scaled;
    logic        acc;

    assign s_axis_tready = !afull;
    assign acc = s_axis_tvalid && s_axis_tready;

    shx_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(acc), .i_word(s_axis_tdata),
        .i_last(s_axis_tlast), .o_push(push), .o_item(fitem)
    );

    shx_queue #(.DEPTH(QDEPTH)) u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(push), .i_item(fitem),
        .i_pop(pop), .o_empty(empty), .o_afull(afull), .o_item(qitem)
    );

    shx_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_empty(empty), .i_item(qitem),
        .o_pop(pop), .i_ready(m_axis_tready), .o_valid(bvalid),
        .o_item(bitem), .o_scaled(scaled)
    );

    assign m_axis_tvalid = bvalid;
    assign m_axis_tuser  = bitem.kind;
    assign m_axis_tlast  = bitem.last;
    // fields from bit 0: header_word, valid_bytes, first_of_header,
    // sample_rate, frame_bytes, scaled_bytes, error_code, fill
    assign m_axis_tdata = {2'b00, bitem.error_code, scaled, bitem.frame_bytes,
                           bitem.rate, bitem.first, bitem.valid_bytes, bitem.word};
endmodule

/* rtl/shx_checker.sv */
// ============================================================================
// shx_checker
// Port-level checks for the sFlow header extractor.
// ============================================================================
`include "sflow_sample_header_extractor_assert.svh"
module shx_checker (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [135:0] m_axis_tdata,
    input logic         m_axis_tuser
);
    `SHX_ASSERT_NEXT(a_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "output word dropped while stalled")
    `SHX_ASSERT_IMP(a_err_zero, i_clk, i_rst_n, m_axis_tvalid && m_axis_tuser, m_axis_tdata[131:0] == '0, "error word carries data")
    `SHX_ASSERT_IMP(a_code, i_clk, i_rst_n, m_axis_tvalid, m_axis_tdata[133:132] != 2'd3, "bad error code")
    `SHX_ASSERT_IMP(a_vb, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tuser, m_axis_tdata[34:32] != 3'd0 && m_axis_tdata[133:132] == 2'd0, "bad header word")
endmodule

bind sflow_sample_header_extractor shx_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata),
    .m_axis_tuser(m_axis_tuser)
);
